FILE: hw/rtl/pva_pkg.sv
// pva_pkg: shared widths, constants, config register codes and the pixel
// payload type of the vibrance adjust block
// no dependencies
package pva_pkg;

  localparam int CH_W      = 8;
  localparam int SAT_BITS  = 12;
  localparam int WIDE_BITS = 22;
  // one quotient bit per divider stage, integer bit plus SAT_BITS fraction bits
  localparam int DIV_STAGES = SAT_BITS + 1;
  localparam int SUM_W  = 10;
  localparam int MEAN_W = 16;
  localparam int DIFF_W = 17;
  localparam int TOT_W  = 26;

  // floor(x / 3) = (x * MEAN_RECIP) >> MEAN_RECIP_SHIFT for x below 2^19
  localparam int          MEAN_RECIP_SHIFT = 20;
  localparam int          MEAN_X_W         = SUM_W + 8;
  localparam int          MEAN_P_W         = MEAN_X_W + MEAN_RECIP_SHIFT;
  localparam logic [19:0] MEAN_RECIP       = 20'd349526;

  localparam int GAIN_FRAC_BITS_DEF = 10;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIBRANCE   = 1'b0,
    CFG_SATURATION = 1'b1
  } pva_cfg_e;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [SUM_W-1:0] sum;
  } pva_pix_t;

endpackage

FILE: hw/rtl/pixel_vibrance_adjust_unit.sv
// pixel_vibrance_adjust_unit: vibrance and saturation adjustment of one rgb
// pixel per transaction, top level with config registers and gain datapath
// depends on pva_pkg and pva_sat_div
//
//   channel   dir  width  contents
//   s_axis    in   24     input pixel
//   m_axis    out  24     adjusted pixel
//   cfg       in   12     vibrance / saturation settings, write only
//
// one pixel per cycle while the output is not stalled; one min/max stage, 13
// divider stages (one saturation bit each), then gain, product and clamp stages.
// reset clears the valid bits and both settings to zero.
// a stalled output holds every stage that has a successor waiting; empty
// stages keep filling, so nothing is dropped or repeated.
module pixel_vibrance_adjust_unit #(
  parameter int GAIN_FRAC_BITS = pva_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red_out, green_out, blue_out
  input  logic                          cfg_we_i,
  input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pva_pkg::CFG_W-1:0]     cfg_data_i
);
  import pva_pkg::*;

  localparam int GAIN_SHIFT = WIDE_BITS - GAIN_FRAC_BITS;
  localparam int GAIN_W     = TOT_W - GAIN_SHIFT;
  localparam int PROD_W     = DIFF_W + GAIN_W;
  localparam int VAL_W      = PROD_W + 1;

  // config registers
  logic signed [CFG_W-1:0] vib_q, sat_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vib_q      <= '0;
      sat_gain_q <= '0;
    end else if (cfg_we_i) begin
      case (pva_cfg_e'(cfg_idx_i))
        CFG_VIBRANCE:   vib_q      <= cfg_data_i;
        CFG_SATURATION: sat_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: max, min, sum
  logic            v1_q, en1;
  logic [CH_W-1:0] max1_q, range1_q;
  pva_pix_t        pix1_q;
  logic [CH_W-1:0] r_in, g_in, b_in, mx, mn;
  logic            div_ready;

  assign r_in = s_axis_tdata[7:0];
  assign g_in = s_axis_tdata[15:8];
  assign b_in = s_axis_tdata[23:16];

  always_comb begin
    mx = r_in;
    mn = r_in;
    if (g_in > mx) mx = g_in;
    if (b_in > mx) mx = b_in;
    if (g_in < mn) mn = g_in;
    if (b_in < mn) mn = b_in;
  end

  assign en1 = !v1_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      max1_q       <= mx;
      range1_q     <= mx - mn;
      pix1_q.red   <= r_in;
      pix1_q.green <= g_in;
      pix1_q.blue  <= b_in;
      pix1_q.sum   <= SUM_W'(r_in) + SUM_W'(g_in) + SUM_W'(b_in);
    end
  end

  // saturation divider
  logic              div_valid, div_take;
  logic [SAT_BITS:0] div_sat;
  pva_pix_t          div_pix;

  pva_sat_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (div_ready),
    .in_max_i    (max1_q),
    .in_range_i  (range1_q),
    .in_pix_i    (pix1_q),
    .out_valid_o (div_valid),
    .out_ready_i (div_take),
    .out_sat_o   (div_sat),
    .out_pix_o   (div_pix)
  );

  // stall chain for the tail stages
  logic vg_q, vp_q, vc_q;
  logic eng, enp, enc;

  assign enc      = !vc_q || m_axis_tready;
  assign enp      = !vp_q || enc;
  assign eng      = !vg_q || enp;
  assign div_take = eng;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vp_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (eng) vg_q <= div_valid;
      if (enp) vp_q <= vg_q;
      if (enc) vc_q <= vp_q;
    end
  end

  // stage g: gain and channel mean
  logic signed [TOT_W-1:0]     sg_term, vg_term, tot;
  logic signed [SAT_BITS+1:0]  inv_sat;
  logic [MEAN_P_W-1:0]         mean_prod;
  logic signed [GAIN_W-1:0]    gain_q;
  logic [MEAN_W-1:0]           mean_g_q, mean_p_q, mean_c;
  logic [2:0][CH_W-1:0]        chan_g_q;

  always_comb begin
    inv_sat   = (SAT_BITS+2)'(signed'(1 << SAT_BITS))
              - signed'({1'b0, div_sat});
    sg_term   = TOT_W'(sat_gain_q) <<< SAT_BITS;
    vg_term   = TOT_W'(vib_q) * TOT_W'(inv_sat);
    tot       = TOT_W'(signed'(1 << WIDE_BITS)) + sg_term + vg_term;
    mean_prod = MEAN_P_W'({div_pix.sum, 8'd0}) * MEAN_P_W'(MEAN_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (eng) begin
      // arithmetic shift floors toward minus infinity
      gain_q      <= GAIN_W'(tot >>> GAIN_SHIFT);
      mean_g_q    <= mean_prod[MEAN_RECIP_SHIFT +: MEAN_W];
      chan_g_q[0] <= div_pix.red;
      chan_g_q[1] <= div_pix.green;
      chan_g_q[2] <= div_pix.blue;
    end
  end

  // stage p: distance from mean times gain
  logic signed [DIFF_W-1:0] diff_w [3];
  logic signed [PROD_W-1:0] prod_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_w[c] = signed'({1'b0, chan_g_q[c], 8'd0}) - signed'({1'b0, mean_g_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (enp) begin
      mean_p_q <= mean_g_q;
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(diff_w[c]) * PROD_W'(gain_q);
      end
    end
  end

  // stage c: back to 8 fractional bits, add mean, clamp
  logic signed [VAL_W-1:0] val_w [3];
  logic [2:0][CH_W-1:0]    res_d, res_q;

  assign mean_c = mean_p_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      val_w[c] = VAL_W'(prod_q[c] >>> GAIN_FRAC_BITS) + VAL_W'(signed'({1'b0, mean_c}));
      if (val_w[c][VAL_W-1]) begin
        res_d[c] = '0;
      end else if (|val_w[c][VAL_W-2:MEAN_W]) begin
        res_d[c] = '1;
      end else begin
        res_d[c] = val_w[c][MEAN_W-1:8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready = en1;
  assign m_axis_tvalid = vc_q;
  assign m_axis_tdata  = {res_q[2], res_q[1], res_q[0]};

endmodule

FILE: hw/rtl/pva_sat_div.sv
// pva_sat_div: pipelined restoring divider giving the saturation fraction
// (range << SAT_BITS) / max, one quotient bit per stage, payload carried alongside
// depends on pva_pkg
module pva_sat_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pva_pkg::CH_W-1:0]  in_max_i,
  input  logic [pva_pkg::CH_W-1:0]  in_range_i,
  input  pva_pkg::pva_pix_t         in_pix_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pva_pkg::SAT_BITS:0] out_sat_o,
  output pva_pkg::pva_pix_t         out_pix_o
);
  import pva_pkg::*;

  localparam int N = DIV_STAGES;

  logic [N-1:0]     v_q;
  logic [N-1:0]     en;
  logic [N-1:0]     zero_q;
  logic [SAT_BITS:0] quo_q [N];
  pva_pix_t         pix_q [N];
  // partial remainder and divisor are not needed past the last stage
  logic [CH_W-1:0]  rem_q [N-1];
  logic [CH_W-1:0]  div_q [N-1];

  logic [CH_W:0]    part_w [N];
  logic [CH_W:0]    sub_w  [N];
  logic [CH_W-1:0]  dv_w   [N];
  logic [N-1:0]     ge_w;

  // stall chain: a stage loads when it is empty or its successor loads
  always_comb begin
    en[N-1] = !v_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    part_w[0] = {1'b0, in_range_i};
    dv_w[0]   = in_max_i;
    for (int k = 1; k < N; k++) begin
      part_w[k] = {rem_q[k-1], 1'b0};
      dv_w[k]   = div_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      ge_w[k]  = part_w[k] >= {1'b0, dv_w[k]};
      sub_w[k] = part_w[k] - {1'b0, dv_w[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      quo_q[0]  <= {{SAT_BITS{1'b0}}, ge_w[0]};
      zero_q[0] <= (in_max_i == '0);
      pix_q[0]  <= in_pix_i;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        quo_q[k]  <= {quo_q[k-1][SAT_BITS-1:0], ge_w[k]};
        zero_q[k] <= zero_q[k-1];
        pix_q[k]  <= pix_q[k-1];
      end
    end
    for (int k = 0; k < N - 1; k++) begin
      if (en[k]) begin
        rem_q[k] <= ge_w[k] ? sub_w[k][CH_W-1:0] : part_w[k][CH_W-1:0];
        div_q[k] <= dv_w[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N-1];
  // black pixel has no saturation
  assign out_sat_o   = zero_q[N-1] ? '0 : quo_q[N-1];
  assign out_pix_o   = pix_q[N-1];

endmodule

FILE: sim/pixel_vibrance_adjust_unit_tb.sv
// pixel_vibrance_adjust_unit_tb: self-checking bench for the vibrance adjust block,
// directed pixel table then random pixel phases under several settings, scored by a predictor
// depends on pva_pkg and pixel_vibrance_adjust_unit
module pixel_vibrance_adjust_unit_tb;

  import pva_pkg::*;

  localparam int GAIN_FRAC   = GAIN_FRAC_BITS_DEF;
  localparam int SETTLE_CYC  = 24;   // pipeline is 17 deep
  localparam int HOLD_CYC    = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int N_PROBES    = 22;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  // one directed row: settings, pixel, and a typed answer where it is obvious
  typedef struct packed {
    logic signed [CFG_W-1:0] vib;
    logic signed [CFG_W-1:0] sat;
    rgb_t                    px;
    logic                    known;
    rgb_t                    want;
  } probe_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  logic signed [CFG_W-1:0] vib_setting;
  logic signed [CFG_W-1:0] sat_setting;
  rgb_t                    pending_pix[$];
  int                      err_count;
  bit                      src_gaps;
  bit                      sink_gaps;
  bit                      hold_req;

  probe_t probes [N_PROBES] = '{
    // reset settings give unity gain
    '{12'sd0, 12'sd0, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
    '{12'sd0, 12'sd0, {8'd255, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
    '{12'sd0, 12'sd0, {8'd0, 8'd0, 8'd255}, 1'b1, {8'd0, 8'd0, 8'd255}},
    '{12'sd0, 12'sd0, {8'd0, 8'd255, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
    '{12'sd0, 12'sd0, {8'd255, 8'd0, 8'd0}, 1'b1, {8'd255, 8'd0, 8'd0}},
    '{12'sd0, 12'sd0, {8'd77, 8'd200, 8'd18}, 1'b1, {8'd77, 8'd200, 8'd18}},
    // vibrance: grey stays put, fully saturated is untouched, black stays black
    '{12'sd1024, 12'sd0, {8'd128, 8'd128, 8'd128}, 1'b1, {8'd128, 8'd128, 8'd128}},
    '{12'sd1024, 12'sd0, {8'd0, 8'd0, 8'd255}, 1'b1, {8'd0, 8'd0, 8'd255}},
    '{12'sd1024, 12'sd0, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
    '{12'sd1024, 12'sd0, {8'd90, 8'd100, 8'd140}, 1'b0, '0},
    '{12'sd1024, 12'sd0, {8'd20, 8'd60, 8'd30}, 1'b0, '0},
    // zero gain collapses to the mean
    '{12'sd0, -12'sd1024, {8'd0, 8'd0, 8'd255}, 1'b1, {8'd85, 8'd85, 8'd85}},
    '{12'sd0, -12'sd1024, {8'd90, 8'd20, 8'd10}, 1'b0, '0},
    // negative gain mirrors about the mean
    '{12'sd0, 12'sh800, {8'd0, 8'd100, 8'd200}, 1'b0, '0},
    '{12'sd0, 12'sh800, {8'd255, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
    '{12'sd0, 12'sh800, {8'd0, 8'd0, 8'd255}, 1'b0, '0},
    // settings beyond the nominal range
    '{12'sd2047, 12'sd2047, {8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{12'sd2047, 12'sd2047, {8'd80, 8'd90, 8'd100}, 1'b0, '0},
    '{12'sh800, 12'sh800, {8'd130, 8'd200, 8'd60}, 1'b0, '0},
    '{12'sh800, 12'sh800, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
    '{12'sd1024, 12'sd1024, {8'd0, 8'd0, 8'd1}, 1'b0, '0},
    '{-12'sd1024, 12'sd1024, {8'd127, 8'd1, 8'd254}, 1'b0, '0}
  };

  pixel_vibrance_adjust_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("FAIL pixel_vibrance_adjust_unit");
    $finish;
  end

  function automatic logic [CH_W-1:0] stretch_channel(longint c, longint mean8, longint gain);
    longint val;
    val = mean8 + ((((c <<< 8) - mean8) * gain) >>> GAIN_FRAC);
    if (val < 0) return '0;
    if ((val >>> 8) > 255) return 8'd255;
    return 8'(val >>> 8);
  endfunction

  function automatic rgb_t vibrance_pixel(rgb_t px);
    longint r, g, b, hi, lo, sat, total, gain, mean8;
    rgb_t   res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    // black pixel counts as unsaturated
    sat = (hi > 0) ? ((hi - lo) <<< SAT_BITS) / hi : 0;
    total = (longint'(1) <<< WIDE_BITS)
          + longint'(sat_setting) * (longint'(1) <<< SAT_BITS)
          + longint'(vib_setting) * ((longint'(1) <<< SAT_BITS) - sat);
    gain  = total >>> (WIDE_BITS - GAIN_FRAC);
    mean8 = ((r + g + b) <<< 8) / 3;
    res.red   = stretch_channel(r, mean8, gain);
    res.green = stretch_channel(g, mean8, gain);
    res.blue  = stretch_channel(b, mean8, gain);
    return res;
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t px;
    int   base;
    px = 24'($urandom);
    case ($urandom_range(5))
      2: begin
        // near grey, low saturation
        base = $urandom_range(247, 8);
        px.red   = 8'(base + $urandom_range(8) - 4);
        px.green = 8'(base + $urandom_range(8) - 4);
        px.blue  = 8'(base + $urandom_range(8) - 4);
      end
      3: begin
        case ($urandom_range(2))
          0: px.red = '0;
          1: px.green = '0;
          default: px.blue = '0;
        endcase
      end
      4: begin
        px.red  = 8'd255;
        px.blue = '0;
      end
      5: begin
        px.red   = $urandom_range(1) ? 8'd255 : 8'd0;
        px.green = $urandom_range(1) ? 8'd255 : 8'd0;
        px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_pixel(rgb_t got);
    rgb_t want;
    if (pending_pix.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel %h", got));
      return;
    end
    want = pending_pix.pop_front();
    if (got.red != want.red)
      report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
    if (got.green != want.green)
      report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
    if (got.blue != want.blue)
      report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
  endtask

  // offer one pixel and wait for its transaction
  task automatic push_pixel(rgb_t px, rgb_t want);
    if (src_gaps && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_pix.push_back(want);
  endtask

  // stop offering, let every result come out, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic configure(logic signed [CFG_W-1:0] vib, logic signed [CFG_W-1:0] sat);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VIBRANCE;
    cfg_data_i <= vib;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SATURATION;
    cfg_data_i <= sat;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    vib_setting = vib;
    sat_setting = sat;
    @(posedge clk_i);
  endtask

  // receiver: scores every output transaction and throttles tready
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_pixel(m_axis_tdata);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYC;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_gaps && $urandom_range(99) < 37);
      end
    end
  end

  initial begin
    rgb_t px;
    logic signed [CFG_W-1:0] vib, sat;
    err_count     = 0;
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    hold_req      = 1'b0;
    vib_setting   = '0;
    sat_setting   = '0;
    rst_ni         = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_VIBRANCE;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].vib != vib_setting || probes[i].sat != sat_setting) begin
        settle();
        configure(probes[i].vib, probes[i].sat);
      end
      push_pixel(probes[i].px,
                 probes[i].known ? probes[i].want : vibrance_pixel(probes[i].px));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin vib = 12'sd1024;  sat = 12'sd0;     end
        1: begin vib = -12'sd1024; sat = -12'sd1024; end
        2: begin vib = 12'sd1024;  sat = 12'sd1024;  end
        3: begin vib = 12'sd2047;  sat = 12'sh800;   end
        4: begin vib = 12'sh800;   sat = 12'sd2047;  end
        7: begin vib = 12'($urandom); sat = 12'($urandom); end
        default: begin
          vib = 12'($urandom_range(2048) - 1024);
          sat = 12'($urandom_range(2048) - 1024);
        end
      endcase
      settle();
      configure(vib, sat);
      src_gaps  = (phase != 5);
      sink_gaps = (phase != 5);
      // sink stalls for a long while, sender keeps offering until the block backs up
      if (phase == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        px = random_pixel();
        push_pixel(px, vibrance_pixel(px));
      end
    end

    settle();
    if (err_count == 0) begin
      $display("PASS pixel_vibrance_adjust_unit");
    end else begin
      $display("FAIL pixel_vibrance_adjust_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pva_pkg.sv
hw/rtl/pva_sat_div.sv
hw/rtl/pixel_vibrance_adjust_unit.sv
sim/pixel_vibrance_adjust_unit_tb.sv
